### sv/bb5_pkg.sv
// shared constants, tables and types for the 5x5 box blur
package bb5_pkg;

   localparam int KERNEL      = 5;
   localparam int LINES       = KERNEL - 1;
   localparam int PAD         = 2 * (KERNEL / 2);
   localparam int TAPS        = KERNEL * KERNEL;
   localparam int FW_W        = 12;
   localparam int FH_W        = 13;
   localparam int ROW_W       = 14;
   localparam int CNT_W       = 5;
   localparam int RECIP_W     = 16;
   localparam int RECIP_SHIFT = 15;
   localparam int SUM_W       = 13;
   localparam int ROWSUM_W    = 11;
   localparam int PIX_W       = 24;
   localparam int DEF_MAX_WIDTH = 2048;
   localparam logic [FW_W-1:0] RESET_WIDTH  = 12'd640;
   localparam logic [FH_W-1:0] RESET_HEIGHT = 13'd480;

   // floor(2^15 / n), zero count treated as one
   localparam logic [RECIP_W-1:0] RECIP [TAPS+1] = '{
      16'd32768, 16'd32768, 16'd16384, 16'd10922, 16'd8192, 16'd6553,
      16'd5461,  16'd4681,  16'd4096,  16'd3640,  16'd3276, 16'd2978,
      16'd2730,  16'd2520,  16'd2340,  16'd2184,  16'd2048, 16'd1927,
      16'd1820,  16'd1724,  16'd1638,  16'd1560,  16'd1489, 16'd1424,
      16'd1365,  16'd1310
   };

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_CALC,
      ST_EMIT
   } state_type;

endpackage

### sv/bb5_lane.sv
// one color lane: masked window sum and divide by neighbor count
module bb5_lane
   import bb5_pkg::*;
(
   input  logic                      clock,
   input  logic [TAPS-1:0][7:0]      pix,
   input  logic [TAPS-1:0]           mask,
   input  logic [CNT_W-1:0]          cnt,
   input  logic [RECIP_W-1:0]        recip,
   output logic [7:0]                mean
);

   logic [KERNEL-1:0][ROWSUM_W-1:0] rowsum_ff, rowsum_in;
   logic [SUM_W-1:0]                total_ff, total_in, total2_ff;
   logic [SUM_W+RECIP_W-1:0]        prod_ff, prod_in;
   logic [7:0]                      mean_ff, mean_in;
   logic [SUM_W-1:0]                q_est;
   logic [SUM_W+CNT_W-1:0]          qc;
   logic [SUM_W+CNT_W-1:0]          rem;

   always_comb begin
      for (int k = 0; k < KERNEL; k++) begin
         rowsum_in[k] = '0;
         for (int d = 0; d < KERNEL; d++) begin
            if (mask[k*KERNEL+d]) begin
               rowsum_in[k] = rowsum_in[k] + ROWSUM_W'(pix[k*KERNEL+d]);
            end
         end
      end
      total_in = '0;
      for (int k = 0; k < KERNEL; k++) begin
         total_in = total_in + SUM_W'(rowsum_ff[k]);
      end
      prod_in = SUM_W'(total_ff) * (SUM_W+RECIP_W)'(recip);
      q_est   = SUM_W'(prod_ff >> RECIP_SHIFT);
      qc      = (SUM_W+CNT_W)'(q_est) * (SUM_W+CNT_W)'(cnt);
      rem     = (SUM_W+CNT_W)'(total2_ff) - qc;
      mean_in = (rem >= (SUM_W+CNT_W)'(cnt)) ? q_est[7:0] + 8'd1 : q_est[7:0];
   end

   always_ff @(posedge clock) begin
      rowsum_ff <= rowsum_in;
      total_ff  <= total_in;
      total2_ff <= total_ff;
      prod_ff   <= prod_in;
      mean_ff   <= mean_in;
   end

   assign mean = mean_ff;

endmodule

### sv/bb5_merge.sv
// merges the three lane results into the registered result beat
module bb5_merge
   import bb5_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic [7:0] blue_mean,
   input  logic [7:0] green_mean,
   input  logic [7:0] red_mean,
   input  logic       last,
   output logic       busy,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_blue_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_red_out,
   output logic       rsp_frame_end
);

   logic       valid_ff, valid_in;
   logic [7:0] blue_ff, green_ff, red_ff;
   logic       end_ff;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         blue_ff  <= blue_mean;
         green_ff <= green_mean;
         red_ff   <= red_mean;
         end_ff   <= last;
      end
   end

   assign busy          = valid_ff && rsp_stall;
   assign rsp_valid     = valid_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_green_out = green_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_frame_end = end_ff;

endmodule

### sv/box_blur_5x5_rgb.sv
// top level of the 5x5 rgb box blur with line store, window and three color lanes
// an accepted beat passes capture, window shift, lane sum and divide, then the result beat
// a new beat is taken only once the last one is done, whether or not it yields a result
// the single-beat sequencer around the lane sum and divide pipeline holds req_stall meanwhile
// synchronous active-high reset clears counters, window, sequencer and result valid flag
// the line store has no reset; unwritten entries only reach taps outside the frame
module box_blur_5x5_rgb
   import bb5_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_blue_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_red_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_red_out,
   output logic        rsp_frame_end,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = $clog2(MAX_WIDTH + PAD + 1);

   logic [FW_W-1:0] fw_ff;
   logic [FH_W-1:0] fh_ff;
   logic [WW-1:0]   w_eff;
   logic [FH_W-1:0] h_eff;

   logic [CW-1:0]    c_ff, c_in;
   logic [ROW_W-1:0] r_ff, r_in;

   state_type state_ff, state_in;
   logic [1:0] wait_ff, wait_in;

   logic [LINES*PIX_W-1:0] mem [MAX_WIDTH];
   logic [LINES*PIX_W-1:0] rd_ff;
   logic [AW-1:0]          addr_ff;
   logic                   in_col_ff;
   logic [PIX_W-1:0]       pix_ff;
   logic                   emit_ff;
   logic                   last_ff;
   logic [KERNEL-1:0]      row_ok_ff, row_ok;
   logic [KERNEL-1:0]      col_ok_ff, col_ok;
   logic [CNT_W-1:0]       cnt_ff;
   logic [RECIP_W-1:0]     recip_ff;

   logic [KERNEL-1:0][KERNEL-1:0][PIX_W-1:0] win_ff, win_in;
   logic [KERNEL-1:0][PIX_W-1:0]             col;

   logic accept;
   logic in_col, in_row, emit, last;
   logic [CW:0]    c_wide, w_pad;
   logic [ROW_W:0] r_wide, h_pad;
   logic [2:0]     n_rows, n_cols;
   logic [CNT_W-1:0] cnt;
   logic [TAPS-1:0]  mask;
   logic [TAPS-1:0][7:0] blue_tap, green_tap, red_tap;
   logic [7:0] blue_mean, green_mean, red_mean;
   logic       load, busy;

   // configuration port
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= RESET_WIDTH;
         fh_ff <= RESET_HEIGHT;
      end else if (psel && penable && pwrite) begin
         unique case (reg_index_type'(paddr[2]))
            REG_WIDTH:  fw_ff <= pwdata[FW_W-1:0];
            REG_HEIGHT: fh_ff <= pwdata[FH_W-1:0];
            default:    fw_ff <= fw_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[2]))
         REG_WIDTH:  prdata = 32'(fw_ff);
         REG_HEIGHT: prdata = 32'(fh_ff);
         default:    prdata = '0;
      endcase
   end

   always_comb begin
      if (fw_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(fw_ff);
      end
      h_eff = (fh_ff == '0) ? FH_W'(1) : fh_ff;
   end

   // position of the incoming beat
   assign accept = req_valid && !req_stall;
   assign c_wide = (CW+1)'(c_ff);
   assign r_wide = (ROW_W+1)'(r_ff);
   assign w_pad  = (CW+1)'(w_eff) + (CW+1)'(PAD);
   assign h_pad  = (ROW_W+1)'(h_eff) + (ROW_W+1)'(PAD);

   always_comb begin
      in_col = c_wide < (CW+1)'(w_eff);
      in_row = r_wide < (ROW_W+1)'(h_eff);
      emit   = (c_wide >= (CW+1)'(PAD)) && (r_wide >= (ROW_W+1)'(PAD)) &&
               (c_wide < w_pad) && (r_wide < h_pad);
      last   = (c_wide == (CW+1)'(w_eff) + (CW+1)'(PAD - 1)) &&
               (r_wide == (ROW_W+1)'(h_eff) + (ROW_W+1)'(PAD - 1));
      n_rows = '0;
      n_cols = '0;
      for (int k = 0; k < KERNEL; k++) begin
         row_ok[k] = (r_wide + (ROW_W+1)'(k) >= (ROW_W+1)'(LINES)) &&
                     (r_wide + (ROW_W+1)'(k) < (ROW_W+1)'(h_eff) + (ROW_W+1)'(LINES));
         col_ok[k] = (c_wide + (CW+1)'(k) >= (CW+1)'(LINES)) &&
                     (c_wide + (CW+1)'(k) < (CW+1)'(w_eff) + (CW+1)'(LINES));
         n_rows = n_rows + 3'(row_ok[k]);
         n_cols = n_cols + 3'(col_ok[k]);
      end
      cnt = CNT_W'(n_rows) * CNT_W'(n_cols);
      if (cnt == '0) begin
         cnt = CNT_W'(1);
      end
   end

   always_comb begin
      c_in = c_ff;
      r_in = r_ff;
      if (accept) begin
         if (c_wide + (CW+1)'(1) >= w_pad) begin
            c_in = '0;
            r_in = (r_wide + (ROW_W+1)'(1) >= h_pad) ? '0 : r_ff + ROW_W'(1);
         end else begin
            c_in = c_ff + CW'(1);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            wait_in  = '0;
            state_in = emit_ff ? ST_CALC : ST_IDLE;
         end
         ST_CALC: begin
            wait_in = wait_ff + 2'd1;
            if (wait_ff == 2'd3) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_EMIT:  load      = !busy;
         default:  req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= '0;
         c_ff     <= '0;
         r_ff     <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         c_ff     <= c_in;
         r_ff     <= r_in;
      end
   end

   // beat capture and line store read
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff   <= c_ff[AW-1:0];
         in_col_ff <= in_col;
         pix_ff    <= (in_col && in_row && !req_action) ?
                      {req_red_in, req_green_in, req_blue_in} : '0;
         emit_ff   <= emit;
         last_ff   <= last;
         row_ok_ff <= row_ok;
         col_ok_ff <= col_ok;
         cnt_ff    <= cnt;
         recip_ff  <= RECIP[cnt];
         if (in_col) begin
            rd_ff <= mem[c_ff[AW-1:0]];
         end
      end
   end

   // column entering the window
   always_comb begin
      for (int k = 0; k < LINES; k++) begin
         col[k] = in_col_ff ? rd_ff[k*PIX_W +: PIX_W] : '0;
      end
      col[LINES] = pix_ff;
      for (int k = 0; k < KERNEL; k++) begin
         for (int d = 0; d < KERNEL - 1; d++) begin
            win_in[k][d] = win_ff[k][d+1];
         end
         win_in[k][KERNEL-1] = col[k];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SHIFT && in_col_ff) begin
         for (int k = 0; k < LINES; k++) begin
            mem[addr_ff][k*PIX_W +: PIX_W] <= col[k+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (state_ff == ST_SHIFT) begin
         win_ff <= win_in;
      end
   end

   // lane inputs
   always_comb begin
      for (int k = 0; k < KERNEL; k++) begin
         for (int d = 0; d < KERNEL; d++) begin
            mask[k*KERNEL+d]      = row_ok_ff[k] && col_ok_ff[d];
            blue_tap[k*KERNEL+d]  = win_ff[k][d][7:0];
            green_tap[k*KERNEL+d] = win_ff[k][d][15:8];
            red_tap[k*KERNEL+d]   = win_ff[k][d][23:16];
         end
      end
   end

   bb5_lane u_lane_blue (
      .clock (clock),
      .pix   (blue_tap),
      .mask  (mask),
      .cnt   (cnt_ff),
      .recip (recip_ff),
      .mean  (blue_mean)
   );

   bb5_lane u_lane_green (
      .clock (clock),
      .pix   (green_tap),
      .mask  (mask),
      .cnt   (cnt_ff),
      .recip (recip_ff),
      .mean  (green_mean)
   );

   bb5_lane u_lane_red (
      .clock (clock),
      .pix   (red_tap),
      .mask  (mask),
      .cnt   (cnt_ff),
      .recip (recip_ff),
      .mean  (red_mean)
   );

   bb5_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .blue_mean     (blue_mean),
      .green_mean    (green_mean),
      .red_mean      (red_mean),
      .last          (last_ff),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_green_out (rsp_green_out),
      .rsp_red_out   (rsp_red_out),
      .rsp_frame_end (rsp_frame_end)
   );

   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("beat accepted while previous beat in flight");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC || state_ff == ST_EMIT) |-> cnt_ff != '0)
      else $error("zero neighbor count in divide");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("result load lost");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      (CW+1)'(c_ff) < (CW+1)'(MAX_WIDTH + PAD))
      else $error("column counter out of range");

endmodule
